// ----- design/cmr_pkg.sv -----
// ----------------------------------------------------------------------------
// cmr_pkg
// shared types and constants of the can multi-frame reassembler
// ----------------------------------------------------------------------------
package cmr_pkg;

  localparam int BYTES_PER_CHUNK = 6;
  localparam int CHUNK_W         = 48;
  localparam int SUM_W           = 32;
  localparam int CNT_W           = 16;
  // widths sized for the largest supported store (64 data frames)
  localparam int IDX_W           = 6;
  localparam int LEN_W           = 9;
  localparam int Q_DEPTH         = 4;
  localparam int Q_PTR_W         = 2;

  // result status codes, carried on out_tuser
  typedef enum logic [2:0] {
    ST_IGNORED  = 3'd0,
    ST_HEAD     = 3'd1,
    ST_DATA     = 3'd2,
    ST_SEQ_ERR  = 3'd3,
    ST_BAD_SUM  = 3'd4,
    ST_CHUNK    = 3'd5,
    ST_LEN_REJ  = 3'd6
  } status_t;

  // frame classes handed from front to back
  typedef enum logic [2:0] {
    K_IGNORE  = 3'd0,
    K_HEAD    = 3'd1,
    K_REJECT  = 3'd2,
    K_SEQ_ERR = 3'd3,
    K_DATA    = 3'd4,
    K_LAST    = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [IDX_W-1:0]   idx;
    logic [CHUNK_W-1:0] chunk;
    logic [2:0]         nb;
    logic [LEN_W-1:0]   len;
    logic [SUM_W-1:0]   exp_sum;
  } cmd_t;

endpackage

// ----- design/cmr_front.sv -----
// ----------------------------------------------------------------------------
// cmr_front
// accepts frames, tracks sequence and remaining length, classifies each frame
// ----------------------------------------------------------------------------
module cmr_front import cmr_pkg::*; #(
  parameter int MAX_DATA_FRAMES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  localparam int MAX_LEN = BYTES_PER_CHUNK * MAX_DATA_FRAMES;
  localparam int SEQ_W   = $clog2(MAX_DATA_FRAMES + 2);

  typedef enum logic {
    M_WAIT,
    M_COLLECT
  } mode_t;

  mode_t            mode_r, mode_nxt;
  logic [SEQ_W-1:0] next_seq_r, next_seq_nxt;
  logic [LEN_W-1:0] remain_r, remain_nxt;

  logic [15:0] seq;
  logic [15:0] len16;
  logic [15:0] seq_m1;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;
  assign seq       = in_tdata[15:0];
  assign len16     = in_tdata[31:16];
  assign seq_m1    = seq - 16'd1;

  always_comb begin
    mode_nxt        = mode_r;
    next_seq_nxt    = next_seq_r;
    remain_nxt      = remain_r;
    q_cmd.kind      = K_IGNORE;
    q_cmd.idx       = seq_m1[IDX_W-1:0];
    q_cmd.chunk     = in_tdata[63:16];
    q_cmd.nb        = (remain_r < LEN_W'(BYTES_PER_CHUNK)) ? remain_r[2:0]
                                                           : 3'(BYTES_PER_CHUNK);
    q_cmd.len       = len16[LEN_W-1:0];
    q_cmd.exp_sum   = in_tdata[63:32];
    if (seq == 16'd0) begin
      if (len16 == 16'd0 || len16 > 16'(MAX_LEN)) begin
        q_cmd.kind = K_REJECT;
        mode_nxt   = M_WAIT;
      end else begin
        q_cmd.kind   = K_HEAD;
        mode_nxt     = M_COLLECT;
        next_seq_nxt = SEQ_W'(1);
        remain_nxt   = len16[LEN_W-1:0];
      end
    end else if (mode_r != M_COLLECT) begin
      q_cmd.kind = K_IGNORE;
    end else if (seq != 16'(next_seq_r) || seq > 16'(MAX_DATA_FRAMES)) begin
      q_cmd.kind = K_SEQ_ERR;
      mode_nxt   = M_WAIT;
    end else begin
      next_seq_nxt = next_seq_r + SEQ_W'(1);
      remain_nxt   = remain_r - LEN_W'(BYTES_PER_CHUNK);
      if (remain_r <= LEN_W'(BYTES_PER_CHUNK)) begin
        // final frame of the message
        q_cmd.kind = K_LAST;
        mode_nxt   = M_WAIT;
      end else begin
        q_cmd.kind = K_DATA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_WAIT;
      next_seq_r <= '0;
      remain_r   <= '0;
    end else if (q_push) begin
      mode_r     <= mode_nxt;
      next_seq_r <= next_seq_nxt;
      remain_r   <= remain_nxt;
    end
  end

endmodule

// ----- design/cmr_queue.sv -----
// ----------------------------------------------------------------------------
// cmr_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module cmr_queue import cmr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t pop_cmd
);

  cmd_t               entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W:0]   count_r;

  assign full    = (count_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign valid   = (count_r != '0);
  assign pop_cmd = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      if (push && !pop)      count_r <= count_r + (Q_PTR_W+1)'(1);
      else if (pop && !push) count_r <= count_r - (Q_PTR_W+1)'(1);
    end
  end

endmodule

// ----- design/cmr_back.sv -----
// ----------------------------------------------------------------------------
// cmr_back
// sums payload, stores chunks, checks the message sum and drives results
// ----------------------------------------------------------------------------
module cmr_back import cmr_pkg::*; #(
  parameter int MAX_DATA_FRAMES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);

  localparam int ADDR_W = (MAX_DATA_FRAMES > 1) ? $clog2(MAX_DATA_FRAMES) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEND
  } state_t;

  state_t state_r;

  logic [CHUNK_W-1:0] mem [MAX_DATA_FRAMES];
  logic [CHUNK_W-1:0] rd_data_r;

  logic [LEN_W-1:0]   len_r;
  logic [SUM_W-1:0]   exp_r;
  logic [SUM_W-1:0]   sum_r;
  logic [CNT_W-1:0]   good_r;
  logic [CNT_W-1:0]   bad_r;
  logic [IDX_W-1:0]   last_idx_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic [LEN_W-1:0]   rd_remain_r;

  logic               out_valid_r;
  status_t            out_status_r;
  logic [4:0]         out_idx_r;
  logic [CHUNK_W-1:0] out_data_r;
  logic [2:0]         out_nb_r;
  logic               out_last_r;
  logic [7:0]         out_len_r;
  logic [CNT_W-1:0]   out_good_r;
  logic [CNT_W-1:0]   out_bad_r;

  logic               out_free;
  logic [10:0]        byte_sum;
  logic [SUM_W-1:0]   sum_nxt;
  logic [2:0]         rd_nb;
  logic               mem_we;

  assign out_free = !out_valid_r || out_tready;
  assign q_pop    = (state_r == S_IDLE) && q_valid && out_free;
  assign mem_we   = q_pop && (q_cmd.kind == K_DATA || q_cmd.kind == K_LAST);
  assign rd_nb    = (rd_remain_r < LEN_W'(BYTES_PER_CHUNK)) ? rd_remain_r[2:0]
                                                            : 3'(BYTES_PER_CHUNK);

  // bytes of the chunk that lie inside the message
  always_comb begin
    byte_sum = '0;
    for (int b = 0; b < BYTES_PER_CHUNK; b++) begin
      if (3'(b) < q_cmd.nb) begin
        byte_sum = byte_sum + 11'(q_cmd.chunk[8*b +: 8]);
      end
    end
  end
  assign sum_nxt = sum_r + SUM_W'(byte_sum);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_cmd.idx[ADDR_W-1:0]] <= q_cmd.chunk;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      rd_data_r <= mem[rd_idx_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      len_r       <= '0;
      exp_r       <= '0;
      sum_r       <= '0;
      good_r      <= '0;
      bad_r       <= '0;
      last_idx_r  <= '0;
      rd_idx_r    <= '0;
      rd_remain_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            out_idx_r  <= '0;
            out_data_r <= '0;
            out_nb_r   <= '0;
            out_last_r <= 1'b1;
            out_good_r <= good_r;
            unique case (q_cmd.kind)
              K_HEAD: begin
                len_r        <= q_cmd.len;
                exp_r        <= q_cmd.exp_sum;
                sum_r        <= '0;
                out_len_r    <= q_cmd.len[7:0];
                out_bad_r    <= bad_r;
                out_status_r <= ST_HEAD;
                out_valid_r  <= 1'b1;
              end
              K_REJECT: begin
                len_r        <= '0;
                out_len_r    <= '0;
                out_bad_r    <= bad_r;
                out_status_r <= ST_LEN_REJ;
                out_valid_r  <= 1'b1;
              end
              K_SEQ_ERR: begin
                out_len_r    <= len_r[7:0];
                out_bad_r    <= bad_r;
                out_status_r <= ST_SEQ_ERR;
                out_valid_r  <= 1'b1;
              end
              K_DATA: begin
                sum_r        <= sum_nxt;
                out_len_r    <= len_r[7:0];
                out_bad_r    <= bad_r;
                out_status_r <= ST_DATA;
                out_valid_r  <= 1'b1;
              end
              K_LAST: begin
                sum_r     <= sum_nxt;
                out_len_r <= len_r[7:0];
                if (sum_nxt != exp_r) begin
                  bad_r        <= bad_r + CNT_W'(1);
                  out_bad_r    <= bad_r + CNT_W'(1);
                  out_status_r <= ST_BAD_SUM;
                  out_valid_r  <= 1'b1;
                end else begin
                  // good message: read the stored chunks out as a run
                  out_bad_r   <= bad_r;
                  out_valid_r <= 1'b0;
                  good_r      <= good_r + CNT_W'(1);
                  last_idx_r  <= q_cmd.idx;
                  rd_idx_r    <= '0;
                  rd_remain_r <= len_r;
                  state_r     <= S_READ;
                end
              end
              default: begin
                out_len_r    <= len_r[7:0];
                out_bad_r    <= bad_r;
                out_status_r <= ST_IGNORED;
                out_valid_r  <= 1'b1;
              end
            endcase
          end else if (out_tready) begin
            out_valid_r <= 1'b0;
          end
        end
        S_READ: begin
          if (out_tready) out_valid_r <= 1'b0;
          state_r <= S_SEND;
        end
        S_SEND: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_CHUNK;
            out_idx_r    <= rd_idx_r[4:0];
            out_data_r   <= rd_data_r;
            out_nb_r     <= rd_nb;
            out_last_r   <= (rd_idx_r == last_idx_r);
            out_len_r    <= len_r[7:0];
            out_good_r   <= good_r;
            out_bad_r    <= bad_r;
            rd_idx_r     <= rd_idx_r + IDX_W'(1);
            rd_remain_r  <= rd_remain_r - LEN_W'(BYTES_PER_CHUNK);
            state_r      <= (rd_idx_r == last_idx_r) ? S_IDLE : S_READ;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {out_bad_r, out_good_r, out_len_r, out_nb_r, out_data_r, out_idx_r};

  a_non_chunk_plain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_CHUNK |-> out_last_r && out_nb_r == 3'd0)
    else $error("non-chunk result carries chunk fields");

  a_chunk_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_CHUNK |-> out_nb_r != 3'd0 && out_nb_r <= 3'd6)
    else $error("chunk byte count out of range");

  a_rd_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> rd_idx_r <= last_idx_r)
    else $error("readout index past final chunk");

  a_send_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == S_SEND) |-> $past(state_r) == S_READ)
    else $error("send entered without a store read");

endmodule

// ----- design/can_multiframe_reassembler.sv -----
// ----------------------------------------------------------------------------
// can_multiframe_reassembler
// reassembles multi-frame messages from 8-byte can frames, checks their sum
// ----------------------------------------------------------------------------
// usage
//   in_*  : one can frame per transaction, in_tdata = the eight frame bytes
//   out_* : one or more results per frame; tuser gives the status, tlast
//           marks the final result caused by a frame
//   each frame gives exactly one result, except a frame that completes a
//   message with a matching sum: it gives one chunk result per data frame
// intake and readout
//   the front takes one frame per cycle while the four-entry command queue
//   has room; each frame's command passes the queue, then the output register
//   a good message reads its chunks out of the store one by one (store read,
//   then output register); the queue is not popped until the run is sent
// reset
//   synchronous rst_n clears state, counters and queue; the chunk store is
//   not cleared, only chunks written in the current message are read
// back-pressure
//   a result waits in the output register while out_tready is low; frames
//   keep being taken until the queue fills, then in_tready drops
// ----------------------------------------------------------------------------
module can_multiframe_reassembler import cmr_pkg::*; #(
  parameter int MAX_DATA_FRAMES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // frame_bytes[63:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,   // chunk_index[4:0], chunk_data[52:5], chunk_bytes[55:53],
                                   // message_length[63:56], good_messages[79:64],
                                   // bad_sums[95:80]
  output logic [2:0]  out_tuser,   // status[2:0]
  output logic        out_tlast    // last_of_run
);

  // front to queue
  logic q_push;
  cmd_t q_push_cmd;
  logic q_full;
  // queue to back
  logic q_pop;
  logic q_valid;
  cmd_t q_pop_cmd;

  // classification of frames against the sequence state
  cmr_front #(
    .MAX_DATA_FRAMES(MAX_DATA_FRAMES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_push_cmd)
  );

  // decouples frame intake from readout stalls
  cmr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(q_push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .pop_cmd (q_pop_cmd)
  );

  // sum check, chunk store and result output
  cmr_back #(
    .MAX_DATA_FRAMES(MAX_DATA_FRAMES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_pop_cmd),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule
